// ===== hdl/tlpd_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpd_pkg: shared definitions of the tagged length-prefix deframer
// Types, register indexes, status codes and default sizes used by the
// deframer and by its port checker.
// ----------------------------------------------------------------------------
package tlpd_pkg;

  // Default number of header bytes: a 32-bit tag followed by a 32-bit length.
  localparam int unsigned HeaderBytesDef = 8;

  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned LenW     = 16;
  localparam int unsigned MaxLenW  = 17;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] CfgFrameTag = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgMaxLen   = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgByteOrd  = 2'd2;

  localparam logic [MaxLenW-1:0] MaxLenRst = 17'h10000;

  // Result status codes carried on tuser.
  typedef enum logic [1:0] {
    StData   = 2'd0,
    StBadTag = 2'd1,
    StBadLen = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhPayload = 2'd1,
    PhHalt    = 2'd2
  } phase_e;

endpackage

// ===== hdl/tagged_length_prefix_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// tagged_length_prefix_deframer_unit: tagged length-prefix message deframer
// Splits a byte stream into messages with a tag and length header, checks
// the header and forwards validated messages with the final byte marked.
// ----------------------------------------------------------------------------
// Output: a payload byte is registered and appears on the output in the cycle
// after it is accepted; once the last byte of a valid header is accepted, the
// burst flag is set and the header bytes then pass in order through the output
// register. Throughput: one payload item per cycle while the output is not
// stalled; header bytes are released through the single output register, during
// which the input is held off.
// Reset: rst_ni clears all control state; a tag or length error halts the block
// until the next reset.
module tagged_length_prefix_deframer_unit #(
  parameter int unsigned HEADER_BYTES = tlpd_pkg::HeaderBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [tlpd_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [tlpd_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [7:0] out_byte
  output logic                          m_axis_tlast,  // end_of_message
  output logic [1:0]                    m_axis_tuser   // [1:0] status
);
  import tlpd_pkg::*;

  localparam int unsigned IdxW = $clog2(HEADER_BYTES);
  localparam logic [LenW-1:0] HdrLen  = LenW'(HEADER_BYTES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(HEADER_BYTES - 1);

  // Configuration registers.
  logic [31:0]        frame_tag_q;
  logic [MaxLenW-1:0] max_len_q;
  logic               byte_order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_tag_q  <= '0;
      max_len_q    <= MaxLenRst;
      byte_order_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgFrameTag: frame_tag_q  <= cfg_wdata_i;
        CfgMaxLen:   max_len_q    <= cfg_wdata_i[MaxLenW-1:0];
        CfgByteOrd:  byte_order_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Control state.
  phase_e          phase_q, phase_d;
  logic [LenW-1:0] pos_q, pos_d;
  logic [LenW-1:0] msg_len_q, msg_len_d;
  logic            burst_q, burst_d;
  logic            burst_eom_q, burst_eom_d;
  logic [IdxW-1:0] idx_q, idx_d;

  // The header is kept in a shift line; once complete, entry k holds byte k.
  logic [7:0] hdr_q [HEADER_BYTES];
  logic [7:0] full_hdr [HEADER_BYTES];

  // Output register.
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  status_e    out_st_q, out_st_d;

  logic        out_free;
  logic        in_acc;
  logic        hdr_done;
  logic [31:0] tag_word;
  logic [31:0] len_word;
  logic        bad_tag;
  logic        bad_len;
  logic [LenW-1:0] pos_inc;

  assign out_free      = !out_valid_q || m_axis_tready;
  // The input waits while the header is released and while the result
  // register is full and not being drained.
  assign s_axis_tready = !burst_q && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pos_inc       = pos_q + 1'b1;

  // The header as it stands once the incoming byte is added at the end.
  always_comb begin
    for (int k = 0; k < HEADER_BYTES - 1; k++) begin
      full_hdr[k] = hdr_q[k+1];
    end
    full_hdr[HEADER_BYTES-1] = s_axis_tdata;
  end

  always_comb begin
    if (byte_order_q) begin
      tag_word = {full_hdr[0], full_hdr[1], full_hdr[2], full_hdr[3]};
      len_word = {full_hdr[4], full_hdr[5], full_hdr[6], full_hdr[7]};
    end else begin
      tag_word = {full_hdr[3], full_hdr[2], full_hdr[1], full_hdr[0]};
      len_word = {full_hdr[7], full_hdr[6], full_hdr[5], full_hdr[4]};
    end
  end

  // A length must fit 16 bits, stay below max_len and cover the header.
  // Values of max_len above 65536 thus act as 65536.
  assign bad_tag  = tag_word != frame_tag_q;
  assign bad_len  = (len_word[31:16] != 16'd0) ||
                    ({1'b0, len_word[15:0]} >= max_len_q) ||
                    (len_word[15:0] < HdrLen);
  assign hdr_done = (phase_q == PhHeader) && (pos_inc == HdrLen);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    msg_len_d   = msg_len_q;
    burst_d     = burst_q;
    burst_eom_d = burst_eom_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_st_d    = out_st_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (burst_q && out_free) begin
      // Release one held header byte per cycle while the output register is free.
      out_valid_d = 1'b1;
      out_byte_d  = hdr_q[idx_q];
      out_last_d  = burst_eom_q && (idx_q == LastIdx);
      out_st_d    = StData;
      idx_d       = idx_q + 1'b1;
      if (idx_q == LastIdx) begin
        burst_d = 1'b0;
      end
    end else if (in_acc) begin
      case (phase_q)
        PhPayload: begin
          out_valid_d = 1'b1;
          out_byte_d  = s_axis_tdata;
          out_st_d    = StData;
          if (pos_inc >= msg_len_q) begin
            out_last_d = 1'b1;
            phase_d    = PhHeader;
            pos_d      = '0;
            msg_len_d  = '0;
          end else begin
            out_last_d = 1'b0;
            pos_d      = pos_inc;
          end
        end
        PhHeader: begin
          pos_d = pos_inc;
          if (hdr_done) begin
            if (bad_tag || bad_len) begin
              // The tag is checked first; either failure halts the block.
              out_valid_d = 1'b1;
              out_byte_d  = '0;
              out_last_d  = 1'b0;
              out_st_d    = bad_tag ? StBadTag : StBadLen;
              phase_d     = PhHalt;
            end else begin
              burst_d     = 1'b1;
              idx_d       = '0;
              burst_eom_d = len_word[15:0] == HdrLen;
              if (len_word[15:0] == HdrLen) begin
                // Header-only message: the next header starts at once.
                pos_d     = '0;
                msg_len_d = '0;
              end else begin
                phase_d   = PhPayload;
                msg_len_d = len_word[15:0];
              end
            end
          end
        end
        default: ;  // Halted: bytes are taken and dropped.
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHeader;
      pos_q       <= '0;
      msg_len_q   <= '0;
      burst_q     <= 1'b0;
      burst_eom_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      msg_len_q   <= msg_len_d;
      burst_q     <= burst_d;
      burst_eom_q <= burst_eom_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_st_q   <= out_st_d;
    if (in_acc && (phase_q == PhHeader)) begin
      for (int k = 0; k < HEADER_BYTES - 1; k++) begin
        hdr_q[k] <= hdr_q[k+1];
      end
      hdr_q[HEADER_BYTES-1] <= s_axis_tdata;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_st_q;

endmodule

// ===== hdl/tlpd_checker.sv =====
// ----------------------------------------------------------------------------
// tlpd_checker: port checks for the tagged length-prefix deframer
// Watches the top-level ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
module tlpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [1:0] m_axis_tuser
);
  import tlpd_pkg::*;

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("stalled result changed");

  // An error result carries no byte and no end mark.
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != StData) |->
      (m_axis_tdata == 8'd0) && !m_axis_tlast)
    else $error("error result with data or end mark");

  // After an error is delivered the block stays silent.
  a_err_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && (m_axis_tuser != StData) |=>
      !m_axis_tvalid)
    else $error("result after an error");

  // Input is held off while a full result register is stalled.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

endmodule

bind tagged_length_prefix_deframer_unit tlpd_checker u_tlpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/deframe_check_pkg.sv =====
// ----------------------------------------------------------------------------
// deframe_check_pkg: expected-result tracker for the deframer testbench
// Predicts the deframer's output bytes from each accepted input byte and
// checks every output item against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package deframe_check_pkg;

  import tlpd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    status_e    status;
  } out_item_t;

  class deframed_byte_checker #(int unsigned HDR = HeaderBytesDef);

    // Shadow copies of the configuration registers.
    logic [31:0]        tag_q;
    logic [MaxLenW-1:0] max_len_q;
    logic               order_q;

    // Mirror of the deframer's message state.
    logic [7:0]         hdr_q[HDR];
    logic [LenW-1:0]    pos_q;
    logic [LenW-1:0]    msg_len_q;
    phase_e             phase_q;

    out_item_t          due_bytes[$];
    int                 errors;

    function new();
      tag_q     = '0;
      max_len_q = MaxLenRst;
      order_q   = 1'b1;
      foreach (hdr_q[k]) hdr_q[k] = '0;
      pos_q     = '0;
      msg_len_q = '0;
      phase_q   = PhHeader;
      errors    = 0;
    endfunction

    function void write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CfgFrameTag: tag_q     = val;
        CfgMaxLen:   max_len_q = val[MaxLenW-1:0];
        CfgByteOrd:  order_q   = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_bytes.size();
    endfunction

    // Assembles a 32-bit header word starting at header byte base.
    function logic [31:0] header_word(int unsigned base);
      logic [31:0] w;
      logic [7:0]  b;
      w = '0;
      for (int unsigned i = 0; i < 4; i++) begin
        b = hdr_q[(base + i) % HDR];
        if (order_q) w = {w[23:0], b};
        else         w[8*i +: 8] = b;
      end
      return w;
    endfunction

    function void push(logic [7:0] data, logic last, status_e status);
      out_item_t it;
      it.data   = data;
      it.last   = last;
      it.status = status;
      due_bytes.push_back(it);
    endfunction

    function void take_rx_byte(logic [7:0] b);
      logic [31:0]        tag;
      logic [31:0]        len;
      logic [MaxLenW-1:0] bound;
      case (phase_q)
        PhPayload: begin
          pos_q++;
          if (pos_q >= msg_len_q) begin
            phase_q   = PhHeader;
            pos_q     = '0;
            msg_len_q = '0;
            push(b, 1'b1, StData);
          end else begin
            push(b, 1'b0, StData);
          end
        end
        PhHeader: begin
          hdr_q[pos_q % HDR] = b;
          pos_q++;
          if (pos_q >= HDR) begin
            tag   = header_word(0);
            len   = header_word(4);
            bound = (max_len_q > MaxLenRst) ? MaxLenRst : max_len_q;
            // The tag is judged before the length.
            if (tag != tag_q) begin
              phase_q = PhHalt;
              push(8'h00, 1'b0, StBadTag);
            end else if (len >= bound || len < HDR) begin
              phase_q = PhHalt;
              push(8'h00, 1'b0, StBadLen);
            end else begin
              for (int unsigned k = 0; k < HDR; k++)
                push(hdr_q[k], (k == HDR - 1) && (len == HDR), StData);
              if (len == HDR) begin
                pos_q     = '0;
                msg_len_q = '0;
              end else begin
                phase_q   = PhPayload;
                msg_len_q = len[LenW-1:0];
              end
            end
          end
        end
        default: ;  // Halted: input bytes are dropped.
      endcase
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_out_byte(logic [7:0] data, logic last, logic [1:0] status);
      out_item_t want;
      if (due_bytes.size() == 0) begin
        report($sformatf("unexpected item data %02h last %0b status %0d",
                         data, last, status));
        return;
      end
      want = due_bytes.pop_front();
      if (data !== want.data)
        report($sformatf("data %02h, expected %02h", data, want.data));
      if (last !== want.last)
        report($sformatf("last %0b, expected %0b", last, want.last));
      if (status !== want.status)
        report($sformatf("status %0d, expected %0d", status, want.status));
    endtask

  endclass

endpackage

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the tagged length-prefix deframer
// Feeds well-formed messages under several register settings with random
// gaps and output stalls, predicts every output item, and ends with one
// malformed header that must raise an error and halt the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  import tlpd_pkg::*;
  import deframe_check_pkg::*;

  localparam int unsigned HDR      = HeaderBytesDef;
  // Chance, in percent, that a side idles in a given cycle.
  localparam int unsigned IDLE_PCT = 38;
  // Number of input items that the random part aims for.
  localparam int unsigned RAND_ITEMS = 200;
  // Quiet cycles allowed after the last result before a register write.
  localparam int unsigned SETTLE   = 2 * HDR + 4;
  // Cycles without any handshake that count as a hang.
  localparam int unsigned STALL_LIMIT = 4000;

  // Kinds of malformed header used for the closing error check.
  typedef enum int unsigned {
    FlawTag,
    FlawShortLen,
    FlawLongLen,
    FlawTinyMax
  } flaw_e;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;   // [7:0] rx_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;         // [7:0] out_byte
  logic                m_axis_tlast;         // end_of_message
  logic [1:0]          m_axis_tuser;         // [1:0] status

  // When set, neither side inserts idle cycles.
  logic                calm          = 1'b0;
  int unsigned         items_sent    = 0;
  int unsigned         stall_cycles  = 0;

  // Register values as last written, used to build well-formed headers.
  logic [31:0]         cur_tag       = '0;
  logic [MaxLenW-1:0]  cur_max_len   = MaxLenRst;
  logic                cur_order     = 1'b1;

  // The tracker's default header size is the package default, as is HDR.
  deframed_byte_checker tracker = new();

  tagged_length_prefix_deframer_unit #(
    .HEADER_BYTES (HDR)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // The receiver stalls at random unless the calm stretch is on.
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Both handshakes are sampled here, in the active region of the edge, so the
  // values seen are those that the block itself saw at that edge. The output
  // is checked first; an input item never produces a result at its own edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_out_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready)
        tracker.take_rx_byte(s_axis_tdata);
    end
    // Watchdog: any handshake restarts the count.
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offers one input item, after a random gap in which each cycle idles with
  // the idle chance, and returns at the edge at which it was accepted. Valid
  // stays high so back-to-back items need no second assignment in one time step.
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IDLE_PCT);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Stops sending and waits until every predicted item has come out, then
  // lets the block settle so that a register write finds it idle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Writes all three registers on consecutive edges; only called while idle.
  task automatic set_config(input logic [31:0] tag, input logic [MaxLenW-1:0] max_len,
                            input logic order);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CfgFrameTag;
    cfg_wdata_i <= tag;
    tracker.write_reg(CfgFrameTag, tag);
    @(posedge clk_i);
    cfg_addr_i  <= CfgMaxLen;
    cfg_wdata_i <= CfgDataW'(max_len);
    tracker.write_reg(CfgMaxLen, CfgDataW'(max_len));
    @(posedge clk_i);
    cfg_addr_i  <= CfgByteOrd;
    cfg_wdata_i <= CfgDataW'(order);
    tracker.write_reg(CfgByteOrd, CfgDataW'(order));
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_tag     = tag;
    cur_max_len = max_len;
    cur_order   = order;
  endtask

  // Sends a header in the current byte order; bytes past the two words are
  // random and are passed through unchanged by the block.
  task automatic send_header(input logic [31:0] tag, input logic [31:0] len);
    logic [31:0] w;
    int unsigned idx;
    for (int unsigned i = 0; i < HDR; i++) begin
      idx = i % 4;
      if (i < 4)      w = tag;
      else if (i < 8) w = len;
      else            w = $urandom();
      send_byte(cur_order ? w[8*(3-idx) +: 8] : w[8*idx +: 8]);
    end
  endtask

  task automatic send_message(input int unsigned len);
    send_header(cur_tag, len);
    repeat (len - HDR) send_byte(8'($urandom()));
  endtask

  // Lengths at or above this value are rejected under the current setting;
  // max_len values beyond 65536 behave as 65536.
  function automatic int unsigned len_bound();
    return (cur_max_len > MaxLenRst) ? int'(MaxLenRst) : int'(cur_max_len);
  endfunction

  // Mostly short messages so that many headers pass; header-only ones often.
  function automatic int unsigned pick_length();
    int unsigned top;
    int unsigned r;
    int unsigned hi;
    top = len_bound() - 1;
    r   = $urandom_range(99);
    if (r < 25 || top <= HDR) return HDR;
    hi = HDR + ((r < 80) ? 20 : 60);
    if (hi > top) hi = top;
    return $urandom_range(HDR + 1, hi);
  endfunction

  function automatic logic [MaxLenW-1:0] pick_max_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return MaxLenW'($urandom_range(HDR + 1, 40));
    if (r < 70) return MaxLenW'($urandom_range(41, 300));
    if (r < 85) return MaxLenRst;
    return MaxLenW'($urandom_range(65537, 131071));
  endfunction

  initial begin
    flaw_e       flaw;
    int unsigned round;
    int unsigned bound;
    logic [31:0] flip;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. First a header-only message under the reset settings:
    // tag zero, big-endian words, so its last header byte must be marked last.
    send_message(HDR);
    drain();
    // All-ones tag, little-endian words and the smallest legal max_len, under
    // which only header-only messages pass.
    set_config(32'hFFFF_FFFF, MaxLenW'(HDR + 1), 1'b0);
    send_message(HDR);
    drain();
    // Oversized max_len acts as 65536; one payload byte with all bits set.
    set_config($urandom(), MaxLenW'($urandom_range(65537, 131071)), 1'b1);
    send_header(cur_tag, HDR + 1);
    send_byte(8'hFF);

    // Random part: rounds of well-formed messages, each round under a fresh
    // register setting. The first round runs without idle cycles on either
    // side, and the second one pauses mid-round until all output is out.
    items_sent = 0;
    round      = 0;
    while (items_sent < RAND_ITEMS) begin
      drain();
      set_config($urandom(), pick_max_len(), 1'($urandom_range(0, 1)));
      calm <= (round == 0);
      for (int unsigned m = 0; m < 6 && items_sent < RAND_ITEMS; m++) begin
        send_message(pick_length());
        if (round == 1 && m == 2) drain();
      end
      round++;
    end

    // Closing part: one malformed header, which must give a single error item
    // and halt the block. Bytes sent after it are taken and dropped.
    drain();
    calm <= 1'b0;
    flaw = flaw_e'($urandom_range(0, 3));
    case (flaw)
      FlawTag: begin
        set_config($urandom(), pick_max_len(), 1'($urandom_range(0, 1)));
        flip = $urandom() | (32'd1 << $urandom_range(0, 31));
        // The tag is judged first, so a bad length alongside must not matter.
        send_header(cur_tag ^ flip, $urandom_range(0, 1) ? pick_length() : $urandom());
      end
      FlawShortLen: begin
        set_config($urandom(), pick_max_len(), 1'($urandom_range(0, 1)));
        send_header(cur_tag, $urandom_range(0, HDR - 1));
      end
      FlawLongLen: begin
        set_config($urandom(), pick_max_len(), 1'($urandom_range(0, 1)));
        bound = len_bound();
        send_header(cur_tag, $urandom_range(0, 1) ? bound
                                                  : $urandom_range(bound, 32'hFFFF_FFFF));
      end
      default: begin
        // A max_len at or below the header size rejects even a header-only
        // message.
        set_config($urandom(), MaxLenW'($urandom_range(0, HDR)), 1'($urandom_range(0, 1)));
        send_header(cur_tag, HDR);
      end
    endcase
    repeat (4) send_byte(8'($urandom()));
    drain();

    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
